FILE: hw/rtl/tct_pkg.sv
// Shared types and constants of the touch contact tracker.
// Used by tct_ctrl, tct_datapath and touch_contact_tracker_top; no dependencies.
package tct_pkg;

  localparam int MaxTouchesDef = 10;
  localparam int IdW           = 16;
  localparam int CoordW        = 16;
  localparam int SlotW         = 4;
  localparam int SDataW        = 80;
  localparam int MDataW        = 88;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_MOVE   = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_FLUSH  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_ADDED    = 2'd0,
    ST_HANDLED  = 2'd1,
    ST_UPDATED  = 2'd2,
    ST_RELEASED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PS_STATIONARY = 2'd0,
    PS_PRESSED    = 2'd1,
    PS_MOVED      = 2'd2,
    PS_RELEASED   = 2'd3
  } pstate_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic rank_clear;
    logic rank_step;
    logic emit_load;
    logic commit;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic pending;
    logic scan_last;
    logic emit_more;
  } sts_t;

endpackage

FILE: hw/rtl/tct_ctrl.sv
// Control state machine of the touch contact tracker.
// Depends on tct_pkg; drives tct_datapath through cmd_t and reads sts_t.
module tct_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  output logic           s_tready_o,
  output logic           m_tvalid_o,
  input  logic           m_tready_i,
  input  tct_pkg::sts_t  sts_i,
  output tct_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RANK,
    S_LOAD,
    S_EMIT
  } state_e;

  state_e state_q;
  logic   s_tready_q;
  logic   m_tvalid_q;

  assign s_tready_o = s_tready_q;
  assign m_tvalid_o = m_tvalid_q;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: cmd_o.capture = s_tvalid_i && s_tready_q;
      S_EXEC: begin
        if (sts_i.req == tct_pkg::REQ_FLUSH) begin
          cmd_o.rank_clear = sts_i.pending;
        end else begin
          cmd_o.exec = 1'b1;
        end
      end
      S_RANK: cmd_o.rank_step = 1'b1;
      S_LOAD: cmd_o.emit_load = 1'b1;
      S_EMIT: begin
        if (m_tready_i) begin
          cmd_o.emit_load = sts_i.emit_more;
          cmd_o.commit    = !sts_i.emit_more;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      s_tready_q <= 1'b1;
      m_tvalid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (s_tvalid_i && s_tready_q) begin
            state_q    <= S_EXEC;
            s_tready_q <= 1'b0;
          end
        end
        S_EXEC: begin
          if (sts_i.req == tct_pkg::REQ_FLUSH && sts_i.pending) begin
            state_q <= S_RANK;
          end else begin
            state_q    <= S_IDLE;
            s_tready_q <= 1'b1;
          end
        end
        S_RANK: begin
          if (sts_i.scan_last) begin
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          state_q    <= S_EMIT;
          m_tvalid_q <= 1'b1;
        end
        S_EMIT: begin
          if (m_tready_i && !sts_i.emit_more) begin
            state_q    <= S_IDLE;
            m_tvalid_q <= 1'b0;
            s_tready_q <= 1'b1;
          end
        end
        default: begin
          state_q    <= S_IDLE;
          s_tready_q <= 1'b1;
          m_tvalid_q <= 1'b0;
        end
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_tready_q && m_tvalid_q))
    else $error("Input ready while a result beat is pending.");

  a_commit_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> s_tready_q && !m_tvalid_q)
    else $error("Report did not return to idle after commit.");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) |=> m_tvalid_q)
    else $error("Loaded result beat not presented.");

endmodule

FILE: hw/rtl/tct_datapath.sv
// Contact table, id ranking and result register of the touch contact tracker.
// Depends on tct_pkg; commanded by tct_ctrl through cmd_t.
module tct_datapath #(
  parameter int MaxTouches = tct_pkg::MaxTouchesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tct_pkg::cmd_t               cmd_i,
  output tct_pkg::sts_t               sts_o,
  input  logic [tct_pkg::SDataW-1:0]  s_data_i,
  input  logic [1:0]                  s_user_i,
  output logic [tct_pkg::MDataW-1:0]  m_data_o,
  output logic [1:0]                  m_user_o,
  output logic                        m_last_o
);

  localparam int IdxW = (MaxTouches > 1) ? $clog2(MaxTouches) : 1;
  localparam int CntW = $clog2(MaxTouches + 1);
  localparam int IdW  = tct_pkg::IdW;
  localparam int CW   = tct_pkg::CoordW;
  localparam int PadW = tct_pkg::MDataW - tct_pkg::SlotW - IdW - 4 * CW;

  tct_pkg::req_e    req_q;
  logic [IdW-1:0]   id_q;
  logic [CW-1:0]    px_q, py_q, sx_q, sy_q;

  logic [MaxTouches-1:0] valid_q;
  logic [IdW-1:0]        ent_id_q [MaxTouches];
  tct_pkg::status_e      ent_st_q [MaxTouches];
  logic [CW-1:0]         ent_px_q [MaxTouches];
  logic [CW-1:0]         ent_py_q [MaxTouches];
  logic [CW-1:0]         ent_sx_q [MaxTouches];
  logic [CW-1:0]         ent_sy_q [MaxTouches];
  logic [IdxW-1:0]       rank_q   [MaxTouches];

  logic [IdxW-1:0] scan_q;
  logic [CntW-1:0] n_q;
  logic [CntW-1:0] k_q;

  logic [tct_pkg::MDataW-1:0] m_data_q;
  tct_pkg::pstate_e           m_user_q;
  logic                       m_last_q;

  logic            hit, has_free, pending, sel_hit;
  logic [IdxW-1:0] hit_idx, free_idx, sel_idx;
  logic            do_add, do_upd, do_rel, do_del;
  logic            scan_last;
  tct_pkg::pstate_e sel_ps;

  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    has_free = 1'b0;
    free_idx = '0;
    pending  = 1'b0;
    sel_hit  = 1'b0;
    sel_idx  = '0;
    for (int i = MaxTouches - 1; i >= 0; i--) begin
      if (valid_q[i] && ent_id_q[i] == id_q) begin
        hit     = 1'b1;
        hit_idx = IdxW'(i);
      end
      if (!valid_q[i]) begin
        has_free = 1'b1;
        free_idx = IdxW'(i);
      end
      if (valid_q[i] && ent_st_q[i] != tct_pkg::ST_HANDLED) begin
        pending = 1'b1;
      end
      if (valid_q[i] && rank_q[i] == k_q[IdxW-1:0]) begin
        sel_hit = 1'b1;
        sel_idx = IdxW'(i);
      end
    end
  end

  assign do_add = cmd_i.exec && !hit && has_free &&
                  (req_q == tct_pkg::REQ_ADD || req_q == tct_pkg::REQ_MOVE);
  assign do_upd = cmd_i.exec && hit && req_q == tct_pkg::REQ_MOVE;
  assign do_rel = cmd_i.exec && hit && req_q == tct_pkg::REQ_REMOVE &&
                  ent_st_q[hit_idx] != tct_pkg::ST_ADDED;
  assign do_del = cmd_i.exec && hit && req_q == tct_pkg::REQ_REMOVE &&
                  ent_st_q[hit_idx] == tct_pkg::ST_ADDED;

  assign scan_last = scan_q == IdxW'(MaxTouches - 1);

  always_comb begin
    case (ent_st_q[sel_idx])
      tct_pkg::ST_ADDED:    sel_ps = tct_pkg::PS_PRESSED;
      tct_pkg::ST_UPDATED:  sel_ps = tct_pkg::PS_MOVED;
      tct_pkg::ST_RELEASED: sel_ps = tct_pkg::PS_RELEASED;
      default:              sel_ps = tct_pkg::PS_STATIONARY;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= tct_pkg::req_e'(s_user_i);
      id_q  <= s_data_i[15:0];
      px_q  <= s_data_i[31:16];
      py_q  <= s_data_i[47:32];
      sx_q  <= s_data_i[63:48];
      sy_q  <= s_data_i[79:64];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int i = 0; i < MaxTouches; i++) begin
        if (do_add && free_idx == IdxW'(i)) begin
          valid_q[i] <= 1'b1;
        end
        if (do_del && hit_idx == IdxW'(i)) begin
          valid_q[i] <= 1'b0;
        end
        if (cmd_i.commit && ent_st_q[i] == tct_pkg::ST_RELEASED) begin
          valid_q[i] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxTouches; i++) begin
      if ((do_add && free_idx == IdxW'(i)) ||
          ((do_upd || do_rel) && hit_idx == IdxW'(i))) begin
        ent_px_q[i] <= px_q;
        ent_py_q[i] <= py_q;
        ent_sx_q[i] <= sx_q;
        ent_sy_q[i] <= sy_q;
      end
      if (do_add && free_idx == IdxW'(i)) begin
        ent_id_q[i] <= id_q;
        ent_st_q[i] <= tct_pkg::ST_ADDED;
      end
      if (do_upd && hit_idx == IdxW'(i) && ent_st_q[i] == tct_pkg::ST_HANDLED) begin
        ent_st_q[i] <= tct_pkg::ST_UPDATED;
      end
      if (do_rel && hit_idx == IdxW'(i)) begin
        ent_st_q[i] <= tct_pkg::ST_RELEASED;
      end
      if (cmd_i.commit && valid_q[i] &&
          (ent_st_q[i] == tct_pkg::ST_ADDED || ent_st_q[i] == tct_pkg::ST_UPDATED)) begin
        ent_st_q[i] <= tct_pkg::ST_HANDLED;
      end
      if (cmd_i.rank_clear) begin
        rank_q[i] <= '0;
      end else if (cmd_i.rank_step && valid_q[scan_q] &&
                   ent_id_q[scan_q] < ent_id_q[i]) begin
        rank_q[i] <= rank_q[i] + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
      n_q    <= '0;
      k_q    <= '0;
    end else begin
      if (cmd_i.rank_clear) begin
        scan_q <= '0;
        n_q    <= '0;
        k_q    <= '0;
      end else if (cmd_i.rank_step) begin
        scan_q <= scan_q + IdxW'(1);
        n_q    <= n_q + CntW'(valid_q[scan_q]);
      end else if (cmd_i.emit_load) begin
        k_q <= k_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      m_data_q <= {{PadW{1'b0}}, ent_sy_q[sel_idx], ent_sx_q[sel_idx], ent_py_q[sel_idx],
                   ent_px_q[sel_idx], ent_id_q[sel_idx], tct_pkg::SlotW'(sel_idx)};
      m_user_q <= sel_ps;
      m_last_q <= k_q == n_q - CntW'(1);
    end
  end

  assign m_data_o = m_data_q;
  assign m_user_o = m_user_q;
  assign m_last_o = m_last_q;

  assign sts_o.req       = req_q;
  assign sts_o.pending   = pending;
  assign sts_o.scan_last = scan_last;
  assign sts_o.emit_more = k_q != n_q;

  a_commit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> !pending)
    else $error("Contacts still pending after report commit.");

  a_rank_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rank_step && scan_last |=> n_q != '0)
    else $error("Report started on an empty table.");

  a_sel_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_load |-> sel_hit)
    else $error("No contact holds the current report rank.");

endmodule

FILE: hw/rtl/touch_contact_tracker_top.sv
// Top level of the touch contact tracker.
// Depends on tct_pkg, tct_ctrl and tct_datapath.
//
//  Group    Dir  Beat contents
//  s_axis   in   tuser: req_type; tdata: touch_id, pos_x, pos_y, screen_x, screen_y
//  m_axis   out  tuser: point_state; tdata: out_slot, out_touch_id, out_pos_x,
//                out_pos_y, out_screen_x, out_screen_y; tlast: last
//
// Add, move and remove are carried out in the execute state before the next beat can be taken,
// and so is a flush when every contact is already handled or the table is empty.
// A flush with pending contacts first ranks the table (one table entry compared against all
// others per cycle), then loads and reports one beat per contact.
// One request is processed at a time; output stalls hold the report in place.
// Reset clears every contact; table payload is written on allocation.
module touch_contact_tracker_top #(
  parameter int MAX_TOUCHES = tct_pkg::MaxTouchesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [tct_pkg::SDataW-1:0]  s_axis_tdata,  // touch_id, pos_x, pos_y, screen_x, screen_y
  input  logic [1:0]                  s_axis_tuser,  // req_type
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [tct_pkg::MDataW-1:0]  m_axis_tdata,  // out_slot, out_touch_id, out_pos_x,
                                                     // out_pos_y, out_screen_x, out_screen_y
  output logic [1:0]                  m_axis_tuser,  // point_state
  output logic                        m_axis_tlast
);

  tct_pkg::cmd_t cmd;
  tct_pkg::sts_t sts;

  tct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tct_datapath #(
    .MaxTouches (MAX_TOUCHES)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .s_data_i (s_axis_tdata),
    .s_user_i (s_axis_tuser),
    .m_data_o (m_axis_tdata),
    .m_user_o (m_axis_tuser),
    .m_last_o (m_axis_tlast)
  );

endmodule
